@@ hw/rtl/bam_pkg.sv @@
// shared types and constants for the bitmap allocation map
package bam_pkg;

    localparam int CELL_BITS            = 128;
    localparam int CELL_IDX_W           = $clog2(CELL_BITS);
    localparam int POS_W                = 10;
    localparam int KIND_W               = 3;
    localparam int CNT_W                = 11;
    localparam int IN_DATA_W            = 24;
    localparam int OUT_DATA_W           = 16;
    localparam int DEFAULT_MAX_ELEMENTS = 1024;
    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR_ALL   = 3'd0,
        KIND_READ        = 3'd1,
        KIND_TOGGLE      = 3'd2,
        KIND_SET         = 3'd3,
        KIND_CLEAR       = 3'd4,
        KIND_FIRST_CLEAR = 3'd5,
        KIND_FIRST_SET   = 3'd6
    } kind_t;

    typedef struct packed {
        logic             active;
        kind_t            kind;
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] last;
        logic             go;
        logic             ok;
        logic [POS_W-1:0] value;
    } tok_t;

endpackage

@@ hw/rtl/bam_cell.sv @@
// one cell of the map chain: holds a slice of the bits and works on the passing request
module bam_cell #(
    parameter int INDEX = 0,
    parameter int PW    = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bam_pkg::tok_t tok_in,
    input  logic [PW-1:0] n_used,
    output bam_pkg::tok_t tok_out
);
    import bam_pkg::*;

    localparam int TAG_W = PW - CELL_IDX_W;
    localparam logic [TAG_W-1:0] CELL_TAG = TAG_W'(INDEX);

    logic [CELL_BITS-1:0]  bits_reg;
    logic [CELL_BITS-1:0]  bits_next;
    tok_t                  tok_reg;
    tok_t                  tok_next;
    logic [CELL_BITS-1:0]  in_use;
    logic [CELL_BITS-1:0]  in_rng;
    logic [CELL_BITS-1:0]  wipe;
    logic [CELL_BITS-1:0]  match;
    logic [CELL_IDX_W-1:0] hit_idx;
    logic [PW-1:0]         hit_pos;
    logic [PW-1:0]         first_w;
    logic [PW-1:0]         last_w;

    assign first_w = PW'(tok_in.first);
    assign last_w  = PW'(tok_in.last);

    for (genvar j = 0; j < CELL_BITS; j++)
    begin : g_bit
        localparam logic [CELL_IDX_W-1:0] JB = CELL_IDX_W'(j);
        logic [PW-1:0] pos;
        logic [PW-1:0] byte_pos;
        assign pos       = {CELL_TAG, JB};
        assign byte_pos  = {CELL_TAG, JB[CELL_IDX_W-1:3], 3'b000};
        assign in_use[j] = pos < n_used;
        assign in_rng[j] = (pos >= first_w) && (pos <= last_w);
        assign wipe[j]   = byte_pos < n_used;
    end

    assign match = in_use & ((tok_in.kind == KIND_FIRST_SET) ? bits_reg : ~bits_reg);

    // lowest matching bit of this cell
    always_comb
    begin
        hit_idx = '0;
        for (int j = CELL_BITS - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                hit_idx = CELL_IDX_W'(j);
            end
        end
    end

    assign hit_pos = {CELL_TAG, hit_idx};

    always_comb
    begin
        bits_next = bits_reg;
        if (tok_in.active)
        begin
            unique case (tok_in.kind)
                KIND_CLEAR_ALL: bits_next = bits_reg & ~wipe;
                KIND_TOGGLE:    if (tok_in.go) bits_next = bits_reg ^ in_rng;
                KIND_SET:       if (tok_in.go) bits_next = bits_reg | in_rng;
                KIND_CLEAR:     if (tok_in.go) bits_next = bits_reg & ~in_rng;
                default:        bits_next = bits_reg;
            endcase
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active)
        begin
            unique case (tok_in.kind)
                KIND_READ:
                begin
                    if (tok_in.ok && (first_w[PW-1:CELL_IDX_W] == CELL_TAG))
                    begin
                        tok_next.value = POS_W'(bits_reg[first_w[CELL_IDX_W-1:0]]);
                    end
                end
                KIND_FIRST_CLEAR, KIND_FIRST_SET:
                begin
                    if (!tok_in.ok && (|match))
                    begin
                        tok_next.ok    = 1'b1;
                        tok_next.value = hit_pos[POS_W-1:0];
                    end
                end
                default: tok_next = tok_in;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ hw/rtl/bitmap_allocation_map_unit.sv @@
// bitmap allocation map: front end, chain of map cells and output register
// path: entry register, each map cell's register in turn, then the output register
// one item at a time: no new item is accepted until the result enters the output register
// the next item is accepted while a finished result still waits at the output
// reset: asynchronous, active low; the whole map clears at once, element_count returns to 1024
module bitmap_allocation_map_unit #(
    parameter int MAX_ELEMENTS = bam_pkg::DEFAULT_MAX_ELEMENTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bam_pkg::CNT_W-1:0]      cfg_data,     // element_count
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bam_pkg::IN_DATA_W-1:0]  s_axis_tdata, // first_pos, last_pos, zero pad
    input  logic [bam_pkg::KIND_W-1:0]     s_axis_tuser, // kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bam_pkg::OUT_DATA_W-1:0] m_axis_tdata, // value, zero pad
    output logic                           m_axis_tuser  // ok
);
    import bam_pkg::*;

    localparam int NUM_CELLS = (MAX_ELEMENTS + CELL_BITS - 1) / CELL_BITS;
    localparam int CMP_W     = $clog2(NUM_CELLS * CELL_BITS) + 1;
    localparam int PW        = (CMP_W > CNT_W) ? CMP_W : CNT_W;

    logic [CNT_W-1:0] count_reg;
    logic [PW-1:0]    count_w;
    logic [PW-1:0]    n_used;
    logic [PW-1:0]    first_w;
    logic [PW-1:0]    last_w;
    logic             in_accept;
    tok_t             entry_reg;
    tok_t             entry_next;
    tok_t             chain [NUM_CELLS+1];
    tok_t             exit_tok;
    logic             busy_reg;
    logic             busy_next;
    logic             pend_reg;
    logic             pend_next;
    logic [POS_W-1:0] pend_value_reg;
    logic             pend_ok_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [POS_W-1:0] out_value_reg;
    logic             out_ok_reg;
    logic             out_free;
    logic             deliver;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    assign count_w = PW'(count_reg);
    assign n_used  = (count_w > PW'(MAX_ELEMENTS)) ? PW'(MAX_ELEMENTS) : count_w;

    assign s_axis_tready = !busy_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign first_w = PW'(s_axis_tdata[POS_W-1:0]);
    assign last_w  = PW'(s_axis_tdata[2*POS_W-1:POS_W]);

    always_comb
    begin
        entry_next        = '0;
        entry_next.active = in_accept;
        entry_next.kind   = kind_t'(s_axis_tuser);
        entry_next.first  = s_axis_tdata[POS_W-1:0];
        entry_next.last   = s_axis_tdata[2*POS_W-1:POS_W];
        entry_next.go     = (first_w < n_used) && (last_w < n_used) && (first_w <= last_w);
        unique case (entry_next.kind)
            KIND_CLEAR_ALL:                     entry_next.ok = 1'b1;
            KIND_READ:                          entry_next.ok = first_w < n_used;
            KIND_TOGGLE, KIND_SET, KIND_CLEAR:  entry_next.ok = entry_next.go;
            default:                            entry_next.ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign chain[0] = entry_reg;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        bam_cell #(
            .INDEX (i),
            .PW    (PW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .n_used  (n_used),
            .tok_out (chain[i+1])
        );
    end

    assign exit_tok = chain[NUM_CELLS];

    assign out_free = !out_valid_reg || m_axis_tready;
    assign deliver  = (pend_reg || exit_tok.active) && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (deliver)
        begin
            out_valid_next = 1'b1;
        end
        pend_next = pend_reg;
        if (exit_tok.active && !out_free)
        begin
            pend_next = 1'b1;
        end
        else if (pend_reg && out_free)
        begin
            pend_next = 1'b0;
        end
        busy_next = busy_reg;
        if (in_accept)
        begin
            busy_next = 1'b1;
        end
        else if (deliver)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            busy_reg      <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exit_tok.active && !out_free)
        begin
            pend_value_reg <= exit_tok.value;
            pend_ok_reg    <= exit_tok.ok;
        end
        if (deliver)
        begin
            if (pend_reg)
            begin
                out_value_reg <= pend_value_reg;
                out_ok_reg    <= pend_ok_reg;
            end
            else
            begin
                out_value_reg <= exit_tok.value;
                out_ok_reg    <= exit_tok.ok;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_value_reg);
    assign m_axis_tuser  = out_ok_reg;

endmodule
